@@ src/wfba_pkg.sv @@
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types, status codes and the sequencer's control store for the
// worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_LOADED    = 2'd0;
  localparam status_t ST_ALLOCATED = 2'd1;
  localparam status_t ST_NO_FIT    = 2'd2;
  localparam status_t ST_BAD_INDEX = 2'd3;

  // control store addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_INIT   = 3'd1;
  localparam step_t STEP_PRIME  = 3'd2;
  localparam step_t STEP_SCAN   = 3'd3;
  localparam step_t STEP_LOAD   = 3'd4;
  localparam step_t STEP_FINISH = 3'd5;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE   = 3'd0,
    COND_LOAD   = 3'd1,
    COND_EMPTY  = 3'd2,
    COND_LAST   = 3'd3,
    COND_ALWAYS = 3'd4
  } cond_t;

  // one control word
  typedef struct packed {
    logic  in_ready;   // take a word on the input channel, wait for it
    logic  init;       // clear scan state, pointer to entry 0
    logic  advance;    // step the read pointer up to the last entry in use
    logic  eval;       // compare the entry just read against the best so far
    logic  emit_load;  // finish a load, wait for room on the output
    logic  emit_alloc; // finish an allocate, wait for room on the output
    logic  loop;       // stay on this step when the condition is false
    cond_t cond;
    step_t target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{in_ready: 1'b0, init: 1'b0, advance: 1'b0, eval: 1'b0,
          emit_load: 1'b0, emit_alloc: 1'b0, loop: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_LOAD;
        w.target   = STEP_LOAD;
      end
      STEP_INIT: begin
        w.init   = 1'b1;
        w.cond   = COND_EMPTY;
        w.target = STEP_FINISH;
      end
      STEP_PRIME: begin
        w.advance = 1'b1;
        w.cond    = COND_NONE;
      end
      STEP_SCAN: begin
        w.advance = 1'b1;
        w.eval    = 1'b1;
        w.loop    = 1'b1;
        w.cond    = COND_LAST;
        w.target  = STEP_FINISH;
      end
      STEP_LOAD: begin
        w.emit_load = 1'b1;
      end
      STEP_FINISH: begin
        w.emit_alloc = 1'b1;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/worst_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a table of block free sizes, run by a small
// microprogram.
// ----------------------------------------------------------------------------
// One word is taken at a time. A load goes from acceptance through the idle
// step and the load step to the output register. For an allocate, the
// control program steps through init and a priming read (init jumps to the
// finish step when no block is in use), then scans the table one entry
// per cycle through its single registered read port, then writes the
// chosen block back and registers the result. A new input word is taken as
// soon as the program is back at idle, even while the previous result still
// waits in the output register. blocks_in_use may be written only while the
// block is idle; values above NUM_BLOCKS act as NUM_BLOCKS. Reset clears
// the table at once through per-entry valid bits.
module worst_fit_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [3:0]  block_index,
  input  logic [15:0] size_value,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  chosen_block,
  output logic [15:0] remaining_size,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_LG = $clog2(NUM_BLOCKS + 1);
  localparam int CW     = (CNT_LG > 5) ? CNT_LG : 5;
  localparam int CMP_W  = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  wfba_pkg::step_t step;
  wfba_pkg::step_t step_next;
  wfba_pkg::ctrl_t ctrl;

  logic [4:0]           blocks_in_use;
  logic [3:0]           idx_r;
  logic [15:0]          req;
  logic [IDX_W-1:0]     ptr;
  logic [IDX_W-1:0]     rd_idx;
  logic                 found;
  logic [IDX_W-1:0]     best;
  logic [SIZE_BITS-1:0] best_size;

  logic [CW-1:0]        count;
  logic [IDX_W-1:0]     last;
  logic                 load_ok;
  logic                 out_blocked;
  logic                 emit_go;
  logic                 cond_hit;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 fits;
  logic [SIZE_BITS-1:0] req_s;
  logic [SIZE_BITS-1:0] alloc_rem;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  // control word for the current step
  assign ctrl     = wfba_pkg::ucode(step);
  assign in_ready = ctrl.in_ready;

  // blocks taking part, clamped to the table size
  always_comb begin
    if (CW'(blocks_in_use) > CW'(NUM_BLOCKS)) begin
      count = CW'(NUM_BLOCKS);
    end else begin
      count = CW'(blocks_in_use);
    end
  end
  assign last    = IDX_W'(count - CW'(1));
  assign load_ok = CW'(idx_r) < count;

  // datapath helpers
  assign req_s       = SIZE_BITS'(req);
  assign alloc_rem   = best_size - req_s;
  assign cur_size    = rd_valid ? rd_data : '0;
  assign fits        = CMP_W'(cur_size) >= CMP_W'(req);
  assign out_blocked = out_valid && !out_ready;
  assign emit_go     = (ctrl.emit_load || ctrl.emit_alloc) && !out_blocked;

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      wfba_pkg::COND_NONE:   cond_hit = 1'b0;
      wfba_pkg::COND_LOAD:   cond_hit = (command == wfba_pkg::CMD_LOAD);
      wfba_pkg::COND_EMPTY:  cond_hit = (count == '0);
      wfba_pkg::COND_LAST:   cond_hit = (rd_idx == last);
      wfba_pkg::COND_ALWAYS: cond_hit = 1'b1;
      default:               cond_hit = 1'b0;
    endcase
  end

  // step sequencing
  always_comb begin
    if (ctrl.in_ready && !in_valid) begin
      step_next = step;
    end else if ((ctrl.emit_load || ctrl.emit_alloc) && out_blocked) begin
      step_next = step;
    end else if (cond_hit) begin
      step_next = ctrl.target;
    end else if (ctrl.loop) begin
      step_next = step;
    end else begin
      step_next = step + wfba_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= wfba_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= 5'd16;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_data;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx_r <= block_index;
      req   <= size_value;
    end
  end

  // scan pointer and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.init) begin
      ptr <= '0;
    end else if (ctrl.advance && ptr != last) begin
      ptr <= ptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ptr;
  end

  // best block so far
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.init) begin
      found <= 1'b0;
    end else if (ctrl.eval && fits && (!found || cur_size > best_size)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval && fits && (!found || cur_size > best_size)) begin
      best      <= rd_idx;
      best_size <= cur_size;
    end
  end

  // table write port: load or write-back
  assign wr_en   = emit_go && ((ctrl.emit_load && load_ok) || (ctrl.emit_alloc && found));
  assign wr_addr = ctrl.emit_load ? IDX_W'(idx_r) : best;
  assign wr_data = ctrl.emit_load ? req_s : alloc_rem;

  wfba_store #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (ptr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (ctrl.emit_load) begin
        chosen_block <= idx_r;
        if (load_ok) begin
          status         <= wfba_pkg::ST_LOADED;
          remaining_size <= 16'(req_s);
        end else begin
          status         <= wfba_pkg::ST_BAD_INDEX;
          remaining_size <= '0;
        end
      end else if (found) begin
        status         <= wfba_pkg::ST_ALLOCATED;
        chosen_block   <= 4'(best);
        remaining_size <= 16'(alloc_rem);
      end else begin
        status         <= wfba_pkg::ST_NO_FIT;
        chosen_block   <= '0;
        remaining_size <= '0;
      end
    end
  end

  // accepted word always enters the load step or the init step
  a_accept_branch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=>
      (step == wfba_pkg::STEP_LOAD || step == wfba_pkg::STEP_INIT))
    else $error("accepted word did not start a load or a scan");

  // the best candidate always covers the request
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (step == wfba_pkg::STEP_SCAN && found) |-> (CMP_W'(best_size) >= CMP_W'(req)))
    else $error("best block smaller than the request");

  // a result is only loaded while the output register is empty or being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> !out_blocked)
    else $error("result written over a pending output word");

  // no-fit words carry zero block and size
  a_no_fit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == wfba_pkg::ST_NO_FIT) |->
      (chosen_block == '0 && remaining_size == '0))
    else $error("no-fit word with nonzero fields");

  // the program counter stays inside the control store
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= wfba_pkg::STEP_FINISH)
    else $error("step outside the control program");

endmodule

@@ src/wfba_store.sv @@
// ----------------------------------------------------------------------------
// wfba_store
// Free-size table: one write port, one registered read port, and a valid
// bit per entry so that every entry reads as not valid after reset until written.
// ----------------------------------------------------------------------------
module wfba_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  output logic             rd_valid
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule
